[rtl/core/csm_pkg.sv]
// ----------------------------------------------------------------------------
// csm_pkg: shared types and constants of the compare-split merge block
// Holds the list length, the derived widths, the payload structs of both
// channels, the store write bundle, the merge command and the back-end states.
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam int MAX_LEN = 32;
    localparam int DATA_W  = 32;
    // Index into one list; at least one bit so that a length of one still works.
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    // Pair count, able to hold MAX_LEN itself.
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    // Store address: bank bit on top of the list index.
    localparam int ADDR_W  = IDX_W + 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] local_value;
        logic signed [DATA_W-1:0] remote_value;
        logic                     keep_lower;
        logic                     last_pair;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] merged_value;
        logic                     last_value;
    } t_out;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] local_value;
        logic [DATA_W-1:0] remote_value;
    } t_st_wr;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] len;
        logic             keep_lower;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MERGE,
        B_FLIP,
        B_DRAIN
    } t_bstate;

endpackage

[rtl/core/csm_front.sv]
// ----------------------------------------------------------------------------
// csm_front: load front end
// Accepts input transactions, writes each pair into the current store bank
// and, on the final pair, hands a merge command to the back end.
// ----------------------------------------------------------------------------
module csm_front
    import csm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_in    i_in_data,
    output logic   o_in_ready,
    input  logic   i_q_full,
    output logic   o_push,
    output t_cmd   o_cmd,
    output t_st_wr o_wr
);

    logic             r_wbank;
    logic             n_wbank;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             accept;
    logic             has_room;
    logic [CNT_W-1:0] cnt_inc;

    // A free bank exists whenever the command queue has room.
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign has_room   = (r_cnt < CNT_W'(MAX_LEN));
    assign cnt_inc    = has_room ? (r_cnt + CNT_W'(1)) : r_cnt;

    always_comb begin
        o_wr.en           = accept && has_room;
        o_wr.addr         = {r_wbank, r_cnt[IDX_W-1:0]};
        o_wr.local_value  = i_in_data.local_value;
        o_wr.remote_value = i_in_data.remote_value;
    end

    assign o_push         = accept && i_in_data.last_pair;
    assign o_cmd.bank       = r_wbank;
    assign o_cmd.len        = cnt_inc;
    assign o_cmd.keep_lower = i_in_data.keep_lower;

    always_comb begin
        n_cnt   = r_cnt;
        n_wbank = r_wbank;
        if (o_push) begin
            n_cnt   = '0;
            n_wbank = !r_wbank;
        end else if (accept) begin
            n_cnt = cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wbank <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_wbank <= n_wbank;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_LEN))
        else $error("pair count exceeds the list length");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (!i_q_full && o_cmd.len != '0))
        else $error("merge command issued without room or with an empty list");

    a_push_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_cnt == '0 && r_wbank != $past(r_wbank)))
        else $error("load did not restart in the other bank");

endmodule

[rtl/core/csm_cmd_q.sv]
// ----------------------------------------------------------------------------
// csm_cmd_q: merge command queue
// Two-entry queue, one entry per store bank, between the load front end and
// the merge back end. The head stays in place until the back end retires it.
// ----------------------------------------------------------------------------
module csm_cmd_q
    import csm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head,
    output logic o_full
);

    t_cmd       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_head  = r_ent[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

endmodule

[rtl/core/csm_back.sv]
// ----------------------------------------------------------------------------
// csm_back: merge back end
// Holds both banks of the local and remote stores, merges the lists named by
// the queue head one value per cycle while the output is not stalled, and
// drives it. The upper half is merged top-down into a buffer, read ascending.
// ----------------------------------------------------------------------------
module csm_back
    import csm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_st_wr i_wr,
    input  logic   i_cmd_valid,
    input  t_cmd   i_cmd,
    output logic   o_pop,
    output logic   o_out_valid,
    output t_out   o_out_data,
    input  logic   i_out_ready
);

    localparam int STORE_D = 2 ** ADDR_W;
    localparam int KEPT_D  = 2 ** IDX_W;

    logic [DATA_W-1:0] r_local_mem  [STORE_D];
    logic [DATA_W-1:0] r_remote_mem [STORE_D];
    logic [DATA_W-1:0] r_kept_mem   [KEPT_D];

    t_bstate                  r_state;
    t_bstate                  n_state;
    logic [IDX_W-1:0]         r_pl;
    logic [IDX_W-1:0]         n_pl;
    logic [IDX_W-1:0]         r_pr;
    logic [IDX_W-1:0]         n_pr;
    logic [CNT_W-1:0]         r_k;
    logic [CNT_W-1:0]         n_k;
    logic signed [DATA_W-1:0] r_rd_l;
    logic signed [DATA_W-1:0] r_rd_r;
    logic signed [DATA_W-1:0] r_rd_k;
    logic                     r_ovalid;
    t_out                     r_out;

    logic [CNT_W-1:0]         nm1;
    logic [CNT_W-1:0]         kwr_idx;
    logic                     k_last;
    logic                     can_push;
    logic                     take_local;
    logic signed [DATA_W-1:0] pick;
    logic                     push;
    t_out                     push_data;
    logic                     kwr_en;

    assign nm1      = i_cmd.len - CNT_W'(1);
    assign kwr_idx  = nm1 - r_k;
    assign k_last   = (r_k == nm1);
    assign can_push = !r_ovalid || i_out_ready;

    // Lower half: strict less-than, so a tie takes the remote value first.
    // Upper half: walking down, a tie takes the local value first.
    assign take_local = i_cmd.keep_lower ? (r_rd_l < r_rd_r) : (r_rd_l >= r_rd_r);
    assign pick       = take_local ? r_rd_l : r_rd_r;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = B_MERGE;
                end
            end
            B_MERGE: begin
                if (i_cmd.keep_lower) begin
                    if (k_last && can_push) begin
                        n_state = B_IDLE;
                    end
                end else if (k_last) begin
                    n_state = B_FLIP;
                end
            end
            B_FLIP: begin
                n_state = B_DRAIN;
            end
            B_DRAIN: begin
                if (k_last && can_push) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        n_pl      = r_pl;
        n_pr      = r_pr;
        n_k       = r_k;
        push      = 1'b0;
        push_data = '0;
        kwr_en    = 1'b0;
        o_pop     = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    n_pl = i_cmd.keep_lower ? '0 : nm1[IDX_W-1:0];
                    n_pr = i_cmd.keep_lower ? '0 : nm1[IDX_W-1:0];
                    n_k  = '0;
                end
            end
            B_MERGE: begin
                if (!i_cmd.keep_lower || can_push) begin
                    if (take_local) begin
                        n_pl = i_cmd.keep_lower ? (r_pl + IDX_W'(1)) : (r_pl - IDX_W'(1));
                    end else begin
                        n_pr = i_cmd.keep_lower ? (r_pr + IDX_W'(1)) : (r_pr - IDX_W'(1));
                    end
                    n_k = r_k + CNT_W'(1);
                    if (i_cmd.keep_lower) begin
                        push                   = 1'b1;
                        push_data.merged_value = pick;
                        push_data.last_value   = k_last;
                        o_pop                  = k_last;
                    end else begin
                        kwr_en = 1'b1;
                        if (k_last) begin
                            n_k = '0;
                        end
                    end
                end
            end
            B_FLIP: begin
            end
            B_DRAIN: begin
                if (can_push) begin
                    push                   = 1'b1;
                    push_data.merged_value = r_rd_k;
                    push_data.last_value   = k_last;
                    n_k                    = r_k + CNT_W'(1);
                    o_pop                  = k_last;
                end
            end
            default: begin
            end
        endcase
    end

    // Read addresses follow the next-cycle pointers, so the registered read
    // data always holds the values at the current pointers.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_local_mem[i_wr.addr]  <= i_wr.local_value;
            r_remote_mem[i_wr.addr] <= i_wr.remote_value;
        end
        r_rd_l <= r_local_mem[{i_cmd.bank, n_pl}];
        r_rd_r <= r_remote_mem[{i_cmd.bank, n_pr}];
    end

    always_ff @(posedge i_clk) begin
        if (kwr_en) begin
            r_kept_mem[kwr_idx[IDX_W-1:0]] <= pick;
        end
        r_rd_k <= r_kept_mem[n_k[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= push_data;
        end
        r_pl <= n_pl;
        r_pr <= n_pr;
        r_k  <= n_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_busy_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != B_IDLE) |-> i_cmd_valid)
        else $error("back end busy without a queued command");

    a_pop_with_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (push && push_data.last_value))
        else $error("command retired without its final result");

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MERGE || r_state == B_DRAIN) |-> (r_k <= nm1))
        else $error("merge index ran past the list length");

endmodule

[rtl/core/compare_split_merge.sv]
// ----------------------------------------------------------------------------
// compare_split_merge: compare-split step of odd-even transposition sort
// Loads two ascending lists pair by pair and emits the lower or upper half of
// their merge in ascending order.
// ----------------------------------------------------------------------------
// Loads take one pair per cycle while the command queue has room. A merge
// takes a setup state, then gives one value per cycle (lower half) while the
// output is not stalled, or merges n steps into a buffer, takes a turn state
// and reads n values out (upper half, n pairs loaded), as each store reads one
// word per cycle.
// Reset clears count, bank, queue, merge state and result valid; stores are not reset.
// ----------------------------------------------------------------------------
module compare_split_merge
    import csm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // The stores are split into two banks. The front end fills one bank while
    // the back end merges the other, so a new load can run alongside a merge.
    // Each finished load leaves a command in the queue naming its bank, its
    // length and the half to keep; a full queue means both banks are taken,
    // and the front end then holds off new transactions.

    t_st_wr wr;
    t_cmd   push_cmd;
    t_cmd   head_cmd;
    logic   push;
    logic   pop;
    logic   q_valid;
    logic   q_full;

    // Front end: takes input transactions, saturates the pair count at the
    // list length and issues a command on the final pair.
    csm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .o_wr       (wr)
    );

    // Command queue: one slot per bank.
    csm_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head_cmd),
        .o_full  (q_full)
    );

    // Back end: merges the bank at the queue head and retires the command
    // with the final result transaction.
    csm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule
